/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, clocked on i_clk and held off while in reset.
`define MI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define MI_ASSERT_NEXT(lbl, cond, nxt, msg) \
    `MI_ASSERT(lbl, (cond) |=> (nxt), msg)

`endif

/* rtl/core/minv_pkg.sv */
// ---------------------------------------------------------------------------
// minv_pkg
// Types, constants and helpers for the 4x4 fixed-point matrix inverse block.
// ---------------------------------------------------------------------------
package minv_pkg;

    localparam int ELEM_W    = 32;   // element width, signed Q16.16
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 4;
    localparam int ACC_W     = 136;  // holds minors, cofactors and determinant
    localparam int QUO_W     = 32;   // quotient bits below the overflow check
    localparam int DIV_W     = 164;  // holds |det| shifted up by QUO_W
    localparam int BIT_W     = 5;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic        [DIV_W-1:0]  t_div;
    typedef logic        [IDX_W-1:0]  t_idx;

    localparam t_elem ELEM_MAX  = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam t_elem ELEM_MIN  = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam t_elem ONE_FIXED = t_elem'(1) << FRAC_BITS;
    localparam t_idx  LAST_IDX  = {IDX_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_FETCH_C,
        ST_MUL,
        ST_OP,
        ST_DIV_INIT,
        ST_DIV,
        ST_NEXT,
        ST_PICK,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DET,
        PH_INV,
        PH_RIGID
    } t_phase;

    typedef enum logic [1:0] {
        SRC_ELEM,
        SRC_NEG_ELEM,
        SRC_TMP,
        SRC_COF
    } t_src;

    typedef enum logic [2:0] {
        OP_SET_TMP,
        OP_SUB_TMP,
        OP_COF,
        OP_DET,
        OP_RIGID
    } t_op;

    // Saturate a wide signed value to the element range.
    function automatic t_elem sat_acc(t_acc v);
        logic [ACC_W-ELEM_W:0] top;
        top = v[ACC_W-1:ELEM_W-1];
        if ((&top) || (~|top)) begin
            return v[ELEM_W-1:0];
        end else if (v[ACC_W-1]) begin
            return ELEM_MIN;
        end else begin
            return ELEM_MAX;
        end
    endfunction

    // Map a 3x3 submatrix index back to the 4x4 index, skipping the deleted one.
    function automatic logic [1:0] skip_idx(logic [1:0] i, logic [1:0] drop);
        return (i < drop) ? i : i + 2'd1;
    endfunction

endpackage

/* rtl/core/minv_in_if.sv */
// ---------------------------------------------------------------------------
// minv_in_if
// Element input channel: one signed matrix element per beat.
// ---------------------------------------------------------------------------
interface minv_in_if import minv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

/* rtl/core/minv_out_if.sv */
// ---------------------------------------------------------------------------
// minv_out_if
// Result channel: one inverse element per beat with its index and flags.
// ---------------------------------------------------------------------------
interface minv_out_if import minv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem result_value;
    t_idx  result_index;
    logic  last_element;
    logic  singular;

    modport source (output valid, output result_value, output result_index,
                    output last_element, output singular, input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input last_element, input singular, output ready);
endinterface

/* rtl/core/matrix4x4_inverse_unit.sv */
// ---------------------------------------------------------------------------
// matrix4x4_inverse_unit
// 4x4 Q16.16 matrix inverse by cofactors, with a rigid-transform fast path.
// ---------------------------------------------------------------------------
// Channel   Dir  Beat contents
// i_in      in   element_value, column-major, 16 beats per matrix
// o_out     out  result_value, result_index, last_element, singular
// i_cfg_*   in   inverse_mode (0 general, 1 rigid)
//
// Loading takes one element per cycle while i_in.valid is high. All products go
// through one bit-serial signed multiplier, fed by the operand fetch states and
// followed by an accumulate step, and the divides through one restoring divider.
// General mode needs 184 products and 16 divides; rigid mode needs 9 products.
// A singular matrix finishes after the 40 determinant products. Input is held
// off from the sixteenth element until the last result beat is taken; each
// result waits in the output register while the consumer stalls. Reset is
// synchronous and clears the load count and mode.
// ---------------------------------------------------------------------------
module matrix4x4_inverse_unit import minv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    minv_in_if.sink     i_in,
    minv_out_if.source  o_out
);

    `include "assert_macros.svh"

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic             r_mode;
    t_idx             r_cnt, n_cnt;
    t_idx             r_k, n_k;
    logic [3:0]       r_step, n_step;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_sing, n_sing;

    t_elem            r_mem [16];
    t_elem            r_rd;
    t_elem            r_mier, n_mier;
    t_acc             r_mcand, n_mcand;
    t_acc             r_prod, n_prod;
    t_acc             r_tmp, n_tmp;
    t_acc             r_cof, n_cof;
    t_acc             r_det, n_det;
    t_div             r_rem, n_rem;
    t_div             r_dsh, n_dsh;
    logic [QUO_W-1:0] r_q, n_q;
    logic             r_ovf, n_ovf;
    logic             r_qneg, n_qneg;
    t_elem            r_oval, n_oval;

    t_idx             rd_addr;
    t_idx             mier_addr, mcand_addr;
    logic [1:0]       dr, dc;
    logic [1:0]       uc_mr, uc_mc, uc_cr, uc_cc;
    t_src             uc_src;
    t_op              uc_op;
    logic             uc_jneg;

    // Deleted row and column of the cofactor in progress.
    always_comb begin
        if (r_phase == PH_DET) begin
            dr = 2'd0;
        end else begin
            dr = r_k[3:2];
        end
        dc = r_k[1:0];
    end

    // Microcode for one cofactor: three 2x2 minors, each scaled by a top-row term, then a determinant term.
    always_comb begin
        uc_mr   = 2'd1;
        uc_mc   = 2'd1;
        uc_cr   = 2'd2;
        uc_cc   = 2'd2;
        uc_src  = SRC_ELEM;
        uc_op   = OP_SET_TMP;
        uc_jneg = 1'b0;
        unique case (r_step)
            4'd0: begin uc_mr = 2'd1; uc_mc = 2'd1; uc_cr = 2'd2; uc_cc = 2'd2; end
            4'd1: begin
                uc_mr = 2'd1; uc_mc = 2'd2; uc_cr = 2'd2; uc_cc = 2'd1;
                uc_op = OP_SUB_TMP;
            end
            4'd2: begin uc_mr = 2'd0; uc_mc = 2'd0; uc_src = SRC_TMP; uc_op = OP_COF; end
            4'd3: begin uc_mr = 2'd1; uc_mc = 2'd0; uc_cr = 2'd2; uc_cc = 2'd2; end
            4'd4: begin
                uc_mr = 2'd1; uc_mc = 2'd2; uc_cr = 2'd2; uc_cc = 2'd0;
                uc_op = OP_SUB_TMP;
            end
            4'd5: begin
                uc_mr = 2'd0; uc_mc = 2'd1; uc_src = SRC_TMP; uc_op = OP_COF;
                uc_jneg = 1'b1;
            end
            4'd6: begin uc_mr = 2'd1; uc_mc = 2'd0; uc_cr = 2'd2; uc_cc = 2'd1; end
            4'd7: begin
                uc_mr = 2'd1; uc_mc = 2'd1; uc_cr = 2'd2; uc_cc = 2'd0;
                uc_op = OP_SUB_TMP;
            end
            4'd8: begin uc_mr = 2'd0; uc_mc = 2'd2; uc_src = SRC_TMP; uc_op = OP_COF; end
            4'd9: begin uc_src = SRC_COF; uc_op = OP_DET; end
            default: begin uc_op = OP_SET_TMP; end
        endcase
        if (r_phase == PH_RIGID) begin
            uc_src = SRC_NEG_ELEM;
            uc_op  = OP_RIGID;
        end
    end

    // Operand addresses: element (row, col) sits at 4*col + row.
    always_comb begin
        if (r_phase == PH_RIGID) begin
            mier_addr  = {r_k[1:0], r_step[1:0]};
            mcand_addr = {2'd3, r_step[1:0]};
        end else if (uc_op == OP_DET) begin
            mier_addr  = {dc, 2'd0};
            mcand_addr = {dc, 2'd0};
        end else begin
            mier_addr  = {skip_idx(uc_mc, dc), skip_idx(uc_mr, dr)};
            mcand_addr = {skip_idx(uc_cc, dc), skip_idx(uc_cr, dr)};
        end
    end

    always_comb begin
        unique case (r_state)
            ST_FETCH_A: rd_addr = mcand_addr;
            ST_NEXT:    rd_addr = (r_phase == PH_RIGID) ? {r_k[1:0], r_k[3:2]} : r_k;
            default:    rd_addr = mier_addr;
        endcase
    end

    // Element store and its registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && i_in.valid) begin
            r_mem[r_cnt] <= i_in.element_value;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        t_acc             addend;
        t_acc             base;
        t_acc             cof_abs, det_abs;
        t_div             num, den;
        logic             ge;
        logic [QUO_W-1:0] q_fin;

        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_step  = r_step;
        n_bit   = r_bit;
        n_sing  = r_sing;
        n_mier  = r_mier;
        n_mcand = r_mcand;
        n_prod  = r_prod;
        n_tmp   = r_tmp;
        n_cof   = r_cof;
        n_det   = r_det;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_ovf   = r_ovf;
        n_qneg  = r_qneg;
        n_oval  = r_oval;

        addend  = '0;
        base    = '0;
        cof_abs = r_cof[ACC_W-1] ? -r_cof : r_cof;
        det_abs = r_det[ACC_W-1] ? -r_det : r_det;
        num     = DIV_W'($unsigned(cof_abs)) << QUO_W;
        den     = DIV_W'($unsigned(det_abs));
        ge      = (r_rem >= r_dsh);
        q_fin   = {r_q[QUO_W-2:0], ge};

        i_in.ready  = (r_state == ST_LOAD);
        o_out.valid = (r_state == ST_OUT);

        unique case (r_state)
            ST_LOAD: begin
                if (i_in.valid) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        n_k    = '0;
                        n_step = '0;
                        n_det  = '0;
                        n_sing = 1'b0;
                        if (r_mode) begin
                            n_phase = PH_RIGID;
                            n_state = ST_NEXT;
                        end else begin
                            n_phase = PH_DET;
                            n_state = ST_FETCH_A;
                        end
                    end
                end
            end
            ST_FETCH_A: begin
                n_state = ST_FETCH_B;
            end
            ST_FETCH_B: begin
                case (uc_src)
                    SRC_ELEM:     n_mcand = t_acc'(r_rd);
                    SRC_NEG_ELEM: n_mcand = -t_acc'(r_rd);
                    SRC_TMP:      n_mcand = r_tmp;
                    default:      n_mcand = r_cof;
                endcase
                n_state = ST_FETCH_C;
            end
            ST_FETCH_C: begin
                n_mier  = r_rd;
                n_prod  = '0;
                n_bit   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                // Sign bit of the multiplier carries negative weight.
                if (r_mier[0]) begin
                    addend = (r_bit == BIT_W'(ELEM_W-1)) ? -r_mcand : r_mcand;
                end
                n_prod  = r_prod + addend;
                n_mier  = r_mier >>> 1;
                n_mcand = r_mcand <<< 1;
                n_bit   = r_bit + 1'b1;
                if (r_bit == BIT_W'(ELEM_W-1)) begin
                    n_state = ST_OP;
                end
            end
            ST_OP: begin
                n_state = ST_FETCH_A;
                n_step  = r_step + 1'b1;
                case (uc_op)
                    OP_SET_TMP: n_tmp = r_prod;
                    OP_SUB_TMP: n_tmp = r_tmp - r_prod;
                    OP_COF: begin
                        base  = (r_step == 4'd2) ? '0 : r_cof;
                        n_cof = (uc_jneg ^ dr[0] ^ dc[0]) ? base - r_prod : base + r_prod;
                        if (r_step == 4'd8 && r_phase == PH_INV) begin
                            n_state = ST_DIV_INIT;
                        end
                    end
                    OP_DET: begin
                        n_det  = r_det + r_prod;
                        n_step = '0;
                        n_k    = r_k + 1'b1;
                        if (r_k == t_idx'(3)) begin
                            n_phase = PH_INV;
                            n_k     = '0;
                            n_sing  = (n_det == '0);
                            n_state = ST_NEXT;
                        end
                    end
                    default: begin
                        base  = (r_step == 4'd0) ? '0 : r_cof;
                        n_cof = base + (r_prod >>> FRAC_BITS);
                        if (r_step == 4'd2) begin
                            n_oval  = sat_acc(n_cof);
                            n_state = ST_OUT;
                        end
                    end
                endcase
            end
            ST_DIV_INIT: begin
                n_rem   = num;
                n_dsh   = den << (QUO_W - 1);
                n_ovf   = (num >= (den << QUO_W));
                n_qneg  = r_cof[ACC_W-1] ^ r_det[ACC_W-1];
                n_q     = '0;
                n_bit   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = q_fin;
                n_dsh = r_dsh >> 1;
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(QUO_W-1)) begin
                    if (r_ovf || q_fin[QUO_W-1]) begin
                        n_oval = r_qneg ? ELEM_MIN : ELEM_MAX;
                    end else begin
                        n_oval = r_qneg ? -t_elem'(q_fin) : t_elem'(q_fin);
                    end
                    n_state = ST_OUT;
                end
            end
            ST_NEXT: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                n_step  = '0;
                n_state = ST_OUT;
                if (r_phase == PH_RIGID) begin
                    if (r_k[3:2] == 2'd3 && r_k[1:0] != 2'd3) begin
                        n_state = ST_FETCH_A;
                    end else if (r_k[1:0] == 2'd3) begin
                        n_oval = (r_k == LAST_IDX) ? ONE_FIXED : '0;
                    end else begin
                        n_oval = r_rd;
                    end
                end else if (r_sing) begin
                    n_oval = r_rd;
                end else begin
                    n_state = ST_FETCH_A;
                end
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_k = r_k + 1'b1;
                    if (r_k == LAST_IDX) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_phase <= PH_DET;
            r_mode  <= 1'b0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_step  <= '0;
            r_bit   <= '0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_sing  <= n_sing;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mier  <= n_mier;
        r_mcand <= n_mcand;
        r_prod  <= n_prod;
        r_tmp   <= n_tmp;
        r_cof   <= n_cof;
        r_det   <= n_det;
        r_rem   <= n_rem;
        r_dsh   <= n_dsh;
        r_q     <= n_q;
        r_ovf   <= n_ovf;
        r_qneg  <= n_qneg;
        r_oval  <= n_oval;
    end

    assign o_out.result_value = r_oval;
    assign o_out.result_index = r_k;
    assign o_out.last_element = (r_k == LAST_IDX);
    assign o_out.singular     = r_sing;

    `MI_ASSERT(a_one_side_open, i_in.ready |-> !o_out.valid, "input open while a result is shown")
    `MI_ASSERT_NEXT(a_last_reloads, o_out.valid && o_out.ready && o_out.last_element, i_in.ready, "no reload after last beat")
    `MI_ASSERT(a_rigid_not_singular, (r_phase == PH_RIGID) |-> !r_sing, "singular set in rigid mode")
    `MI_ASSERT_NEXT(a_mul_ends, r_state == ST_MUL && r_bit == BIT_W'(ELEM_W-1), r_state == ST_OP, "multiply overran")

endmodule

/* tb/minv_tb_if.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// minv_tb_if
// Interfaces come from the RTL; this file keeps the timescale in line for the
// testbench side and holds the wide type of the inverse predictor and the result record.
// ---------------------------------------------------------------------------
package minv_tb_pkg;
    import minv_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        t_elem value;
        t_idx  index;
        logic  last;
        logic  sing;
    } t_result;
endpackage

/* tb/tb_matrix4x4_inverse_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_matrix4x4_inverse_unit
// Streams whole 4x4 matrices into the inverse unit in both modes, predicts
// every result beat with exact wide arithmetic and checks each beat in order.
// ---------------------------------------------------------------------------
module tb_matrix4x4_inverse_unit;
    import minv_pkg::*;
    import minv_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam logic MODE_GENERAL = 1'b0;
    localparam logic MODE_RIGID   = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    minv_in_if  in_ch ();
    minv_out_if out_ch ();

    matrix4x4_inverse_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_elem   pending_elems[$];
    t_result expected_results[$];
    t_elem   shadow_store[16];
    int      shadow_count;
    logic    shadow_mode;
    logic    in_taken;
    logic    calm;
    int      errors;
    int      cycles;

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic t_elem clip(t_wide v);
        if (v > t_wide'(ELEM_MAX)) return ELEM_MAX;
        if (v < t_wide'(ELEM_MIN)) return ELEM_MIN;
        return v[ELEM_W-1:0];
    endfunction

    function automatic t_wide at(int r, int c);
        return t_wide'(shadow_store[4*c + r]);
    endfunction

    function automatic t_wide cofactor(int dr, int dc);
        int    rr[3];
        int    cc[3];
        int    n;
        t_wide a[3][3];
        t_wide s;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != dr) begin rr[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != dc) begin cc[n] = i; n++; end
        for (int i = 0; i < 9; i++) a[i/3][i%3] = at(rr[i/3], cc[i%3]);
        s = a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
          - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
          + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
        return ((dr + dc) % 2) ? -s : s;
    endfunction

    // Work out the sixteen result beats of the stored matrix.
    task automatic predict_inverse();
        t_elem res[16];
        t_wide cof[4][4];
        t_wide det;
        t_wide acc;
        logic  sing;
        sing = 1'b0;
        if (shadow_mode == MODE_RIGID) begin
            for (int r = 0; r < 3; r++) begin
                acc = '0;
                for (int c = 0; c < 3; c++) res[4*c + r] = shadow_store[4*r + c];
                for (int k = 0; k < 3; k++) acc += ((-at(k, 3)) * at(k, r)) >>> FRAC_BITS;
                res[12 + r] = clip(acc);
            end
            for (int c = 0; c < 3; c++) res[4*c + 3] = '0;
            res[15] = clip(t_wide'(1) <<< FRAC_BITS);
        end else begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++) cof[r][c] = cofactor(r, c);
            det = '0;
            for (int c = 0; c < 4; c++) det += at(0, c) * cof[0][c];
            if (det == 0) begin
                sing = 1'b1;
                for (int k = 0; k < 16; k++) res[k] = shadow_store[k];
            end else begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        res[4*c + r] = clip((cof[c][r] <<< (2*FRAC_BITS)) / det);
            end
        end
        for (int k = 0; k < 16; k++)
            expected_results.push_back('{res[k], t_idx'(k), k == 15, sing});
    endtask

    // Sample both channels, keep the shadow state and check result beats.
    always @(posedge clk) begin
        t_result exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (!rst_n) begin
            shadow_count = 0;
            shadow_mode  = MODE_GENERAL;
            in_taken    <= 1'b0;
        end else begin
            if (cfg_we) shadow_mode = cfg_wdata;
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                shadow_store[shadow_count] = in_ch.element_value;
                if (shadow_count == 15) begin
                    shadow_count = 0;
                    predict_inverse();
                end else begin
                    shadow_count++;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected beat value=%h index=%0d", $time,
                             out_ch.result_value, out_ch.result_index);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.result_value !== exp_r.value ||
                        out_ch.result_index !== exp_r.index ||
                        out_ch.last_element !== exp_r.last ||
                        out_ch.singular !== exp_r.sing) begin
                        $display("%0t: mismatch expected %h/%0d/%b/%b actual %h/%0d/%b/%b",
                                 $time, exp_r.value, exp_r.index, exp_r.last, exp_r.sing,
                                 out_ch.result_value, out_ch.result_index,
                                 out_ch.last_element, out_ch.singular);
                        errors++;
                    end
                end
            end
        end
    end

    // Drive element beats and result back-pressure on the falling edge.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_ch.valid || in_taken) begin
                if (pending_elems.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
                    in_ch.valid         <= 1'b1;
                    in_ch.element_value <= pending_elems.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    task automatic write_mode(logic m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (!(pending_elems.size() == 0 && !in_ch.valid &&
                 expected_results.size() == 0)) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // Queue one matrix of the given flavor.
    task automatic queue_matrix(int kind);
        t_elem m[16];
        for (int k = 0; k < 16; k++) begin
            case (kind)
                0: m[k] = t_elem'($urandom);
                1: m[k] = (k % 5 == 0) ? t_elem'(($urandom_range(1, 4) << FRAC_BITS)
                                        * ($urandom_range(1) ? 1 : -1))
                                       : t_elem'($urandom_range(65535)) - 32768;
                2: m[k] = (k >= 4 && k < 8) ? m[k-4] : t_elem'($urandom);
                default: m[k] = t_elem'($urandom_range(15)) - 8;
            endcase
        end
        for (int k = 0; k < 16; k++) pending_elems.push_back(m[k]);
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.element_value = '0;
        out_ch.ready        = 1'b0;
        calm                = 1'b0;
        errors              = 0;
        cycles              = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity, then an all-maximum matrix whose determinant is zero.
        write_mode(MODE_GENERAL);
        for (int k = 0; k < 16; k++) pending_elems.push_back((k % 5 == 0) ? ONE_FIXED : '0);
        for (int k = 0; k < 16; k++) pending_elems.push_back(ELEM_MAX);
        drain();

        // Rigid with extreme rotation and translation entries.
        write_mode(MODE_RIGID);
        for (int k = 0; k < 16; k++) pending_elems.push_back((k % 2) ? ELEM_MIN : ELEM_MAX);
        drain();

        for (int p = 0; p < 4; p++) begin
            calm = (p == 2);
            write_mode(p[0] ? MODE_RIGID : MODE_GENERAL);
            queue_matrix($urandom_range(3));
            queue_matrix(p);
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
